FILE: hdl/gdft_pkg.sv
package gdft_pkg;

  localparam int VERTEX_W = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int UPC_W    = 3;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(16);

  typedef enum logic [STATUS_W-1:0] {
    ST_VISIT   = 2'd0,
    ST_STORED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_BAD_SRC = 2'd3
  } status_e;

  // datapath action of one microstep
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LATCH  = 3'd1,
    OP_EDGE   = 3'd2,
    OP_TSTART = 3'd3,
    OP_TOP    = 3'd4,
    OP_VISIT  = 3'd5,
    OP_FLUSH  = 3'd6
  } op_e;

  // jump condition of one microstep
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_NO_REQ   = 3'd1,
    C_IS_TRAV  = 3'd2,
    C_SRC_BAD  = 3'd3,
    C_NO_NB    = 3'd4,
    C_DEPTH_NZ = 3'd5
  } cond_e;

  localparam logic [UPC_W-1:0] STEP_FETCH    = 3'd0;
  localparam logic [UPC_W-1:0] STEP_DISPATCH = 3'd1;
  localparam logic [UPC_W-1:0] STEP_EDGE     = 3'd2;
  localparam logic [UPC_W-1:0] STEP_TSTART   = 3'd3;
  localparam logic [UPC_W-1:0] STEP_TOP      = 3'd4;
  localparam logic [UPC_W-1:0] STEP_VISIT    = 3'd5;
  localparam logic [UPC_W-1:0] STEP_POPCHK   = 3'd6;
  localparam logic [UPC_W-1:0] STEP_FINISH   = 3'd7;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  // status from datapath and port side to the sequencer
  typedef struct packed {
    logic req;
    logic is_trav;
    logic src_bad;
    logic no_nb;
    logic depth_nz;
    logic blocked;
  } seq_flags_t;

  typedef struct packed {
    logic                valid;
    logic [VERTEX_W-1:0] vertex;
    status_e             status;
    logic                last;
  } emit_t;

  function automatic ctrl_word_t ucode_rom(logic [UPC_W-1:0] addr);
    ctrl_word_t cw;
    unique case (addr)
      STEP_FETCH:    cw = '{op: OP_LATCH,  cond: C_NO_REQ,   target: STEP_FETCH};
      STEP_DISPATCH: cw = '{op: OP_NOP,    cond: C_IS_TRAV,  target: STEP_TSTART};
      STEP_EDGE:     cw = '{op: OP_EDGE,   cond: C_ALWAYS,   target: STEP_FETCH};
      STEP_TSTART:   cw = '{op: OP_TSTART, cond: C_SRC_BAD,  target: STEP_FETCH};
      STEP_TOP:      cw = '{op: OP_TOP,    cond: C_NO_NB,    target: STEP_POPCHK};
      STEP_VISIT:    cw = '{op: OP_VISIT,  cond: C_ALWAYS,   target: STEP_TOP};
      STEP_POPCHK:   cw = '{op: OP_NOP,    cond: C_DEPTH_NZ, target: STEP_TOP};
      STEP_FINISH:   cw = '{op: OP_FLUSH,  cond: C_ALWAYS,   target: STEP_FETCH};
      default:       cw = '{op: OP_NOP,    cond: C_ALWAYS,   target: STEP_FETCH};
    endcase
    return cw;
  endfunction

endpackage

FILE: hdl/gdft_useq.sv
module gdft_useq
  import gdft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ctrl_word_t cw_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  logic             take;

  assign cw_o = ucode_rom(upc_q);

  always_comb begin
    unique case (cw_o.cond)
      C_ALWAYS:   take = 1'b1;
      C_NO_REQ:   take = !flags_i.req;
      C_IS_TRAV:  take = flags_i.is_trav;
      C_SRC_BAD:  take = flags_i.src_bad;
      C_NO_NB:    take = flags_i.no_nb;
      C_DEPTH_NZ: take = flags_i.depth_nz;
      default:    take = 1'b1;
    endcase
  end

  always_comb begin
    if (flags_i.blocked) begin
      upc_d = upc_q;
    end else if (take) begin
      upc_d = cw_o.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

FILE: hdl/gdft_dp.sv
module gdft_dp
  import gdft_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_word_t          cw_i,
  input  logic                adv_i,
  input  logic [CFG_W-1:0]    vcount_i,
  input  logic                in_valid_i,
  input  logic                command_i,
  input  logic [VERTEX_W-1:0] edge_from_i,
  input  logic [VERTEX_W-1:0] edge_to_i,
  input  logic [VERTEX_W-1:0] source_vertex_i,
  output emit_t               emit_o,
  output logic                is_trav_o,
  output logic                src_bad_o,
  output logic                no_nb_o,
  output logic                depth_nz_o
);

  // vertex indices are VERTEX_W bits wide, so no more than this many are reachable
  localparam int NV  = (MAX_VERTICES < (1 << VERTEX_W)) ? MAX_VERTICES : (1 << VERTEX_W);
  localparam int VIW = $clog2(NV);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int SW  = $clog2(NV + 1);
  localparam int AW  = $clog2(NV * MAX_DEGREE);

  logic                cmd_q;
  logic [VERTEX_W-1:0] u_q, v_q, s_q;
  logic [DW-1:0]       ncnt_q [NV];
  logic [NV-1:0]       visited_q;
  logic [SW-1:0]       depth_q;
  logic [VIW-1:0]      stk_vtx_q [NV];
  logic [DW-1:0]       stk_pos_q [NV];
  logic [VIW-1:0]      nbr_mem [NV * MAX_DEGREE];
  logic [VIW-1:0]      nb_q;
  logic [VIW-1:0]      pend_q;

  logic [VIW-1:0] u_idx, s_idx, top_idx, top_vtx, push_idx;
  logic [DW-1:0]  top_pos, u_cnt;
  logic           edge_ok, has_nb, visit_ok;
  logic [AW-1:0]  waddr, raddr;

  function automatic logic idx_ok(logic [VERTEX_W-1:0] x, logic [CFG_W-1:0] lim);
    return ({1'b0, x} < lim) && (32'(x) < MAX_VERTICES);
  endfunction

  assign u_idx    = u_q[VIW-1:0];
  assign s_idx    = s_q[VIW-1:0];
  assign top_idx  = VIW'(depth_q - SW'(1));
  assign push_idx = depth_q[VIW-1:0];
  assign top_vtx  = stk_vtx_q[top_idx];
  assign top_pos  = stk_pos_q[top_idx];
  assign u_cnt    = ncnt_q[u_idx];

  assign edge_ok  = idx_ok(u_q, vcount_i) && idx_ok(v_q, vcount_i) &&
                    (u_cnt != DW'(MAX_DEGREE));
  assign has_nb   = top_pos < ncnt_q[top_vtx];
  assign visit_ok = idx_ok(VERTEX_W'(nb_q), vcount_i) && !visited_q[nb_q] &&
                    (depth_q != SW'(NV));

  assign waddr = AW'(u_idx) * AW'(MAX_DEGREE) + AW'(u_cnt);
  assign raddr = AW'(top_vtx) * AW'(MAX_DEGREE) + AW'(top_pos);

  assign is_trav_o  = cmd_q;
  assign src_bad_o  = !idx_ok(s_q, vcount_i);
  assign no_nb_o    = !has_nb;
  assign depth_nz_o = depth_q != '0;

  always_comb begin
    emit_o = '{valid: 1'b0, vertex: '0, status: ST_VISIT, last: 1'b1};
    unique case (cw_i.op)
      OP_EDGE: begin
        emit_o.valid  = 1'b1;
        emit_o.status = edge_ok ? ST_STORED : ST_DROPPED;
      end
      OP_TSTART: begin
        emit_o.valid  = src_bad_o;
        emit_o.status = ST_BAD_SRC;
      end
      OP_VISIT: begin
        // a newly reached vertex releases the previous one, not yet last
        emit_o.valid  = visit_ok;
        emit_o.vertex = VERTEX_W'(pend_q);
        emit_o.last   = 1'b0;
      end
      OP_FLUSH: begin
        emit_o.valid  = 1'b1;
        emit_o.vertex = VERTEX_W'(pend_q);
      end
      default: ;
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cw_i.op == OP_LATCH && in_valid_i) begin
      cmd_q <= command_i;
      u_q   <= edge_from_i;
      v_q   <= edge_to_i;
      s_q   <= source_vertex_i;
    end
  end

  // neighbor list memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (adv_i && cw_i.op == OP_EDGE && edge_ok) begin
      nbr_mem[waddr] <= v_q[VIW-1:0];
    end
    if (adv_i && cw_i.op == OP_TOP && has_nb) begin
      nb_q <= nbr_mem[raddr];
    end
  end

  // stack frames and pending visit
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      unique case (cw_i.op)
        OP_TSTART: begin
          if (!src_bad_o) begin
            stk_vtx_q[0] <= s_idx;
            stk_pos_q[0] <= '0;
            pend_q       <= s_idx;
          end
        end
        OP_TOP: begin
          if (has_nb) begin
            stk_pos_q[top_idx] <= top_pos + DW'(1);
          end
        end
        OP_VISIT: begin
          if (visit_ok) begin
            stk_vtx_q[push_idx] <= nb_q;
            stk_pos_q[push_idx] <= '0;
            pend_q              <= nb_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        ncnt_q[i] <= '0;
      end
      visited_q <= '0;
      depth_q   <= '0;
    end else if (adv_i) begin
      unique case (cw_i.op)
        OP_EDGE: begin
          if (edge_ok) begin
            ncnt_q[u_idx] <= u_cnt + DW'(1);
          end
        end
        OP_TSTART: begin
          if (!src_bad_o) begin
            // fresh marks with only the source set
            visited_q <= NV'(1) << s_idx;
            depth_q   <= SW'(1);
          end
        end
        OP_TOP: begin
          if (!has_nb) begin
            depth_q <= depth_q - SW'(1);
          end
        end
        OP_VISIT: begin
          if (visit_ok) begin
            visited_q[nb_q] <= 1'b1;
            depth_q         <= depth_q + SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/graph_depth_first_traversal_core.sv
// Add-edge request: fetch, dispatch and edge microsteps, with the status result registered
// at the output. Source out of range: fetch, dispatch and traversal-start microsteps.
// Traverse request: fetch, dispatch, traversal start, then top and visit per stored neighbor
// examined, top and pop check per stack pop, and finish to flush the final visit; each step
// is one microcode word issue and the neighbor memory read port is used once per examined
// neighbor. Output stalls hold the microstep. One request at a time, taken only at fetch.
// Reset (async, active low): vertex_count 16, neighbor lists empty, no output pending.
module graph_depth_first_traversal_core
  import gdft_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [VERTEX_W-1:0] edge_from_i,
  input  logic [VERTEX_W-1:0] edge_to_i,
  input  logic [VERTEX_W-1:0] source_vertex_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VERTEX_W-1:0] visited_vertex_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                last_o
);

  logic [CFG_W-1:0]    vcount_q;
  logic                out_valid_q;
  logic [VERTEX_W-1:0] out_vtx_q;
  status_e             out_status_q;
  logic                out_last_q;

  ctrl_word_t cw;
  seq_flags_t flags;
  emit_t      emit;
  logic       blocked, adv;
  logic       is_trav, src_bad, no_nb, depth_nz;

  assign blocked    = emit.valid && out_valid_q && !out_ready_i;
  assign adv        = !blocked;
  assign in_ready_o = (cw.op == OP_LATCH);

  assign flags = '{req: in_valid_i, is_trav: is_trav, src_bad: src_bad, no_nb: no_nb,
                   depth_nz: depth_nz, blocked: blocked};

  gdft_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  gdft_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cw_i            (cw),
    .adv_i           (adv),
    .vcount_i        (vcount_q),
    .in_valid_i      (in_valid_i),
    .command_i       (command_i),
    .edge_from_i     (edge_from_i),
    .edge_to_i       (edge_to_i),
    .source_vertex_i (source_vertex_i),
    .emit_o          (emit),
    .is_trav_o       (is_trav),
    .src_bad_o       (src_bad),
    .no_nb_o         (no_nb),
    .depth_nz_o      (depth_nz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid && adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && adv) begin
      out_vtx_q    <= emit.vertex;
      out_status_q <= emit.status;
      out_last_q   <= emit.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign visited_vertex_o = out_vtx_q;
  assign status_o         = out_status_q;
  assign last_o           = out_last_q;

  // the sequencer leaves fetch right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted on back-to-back cycles");

  // a blocked result holds the microstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocked |=> $stable(cw))
    else $error("microstep advanced while its result was blocked");

  // status-only results carry vertex zero and close their request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_VISIT) |-> last_o && (visited_vertex_o == '0))
    else $error("malformed status result");

endmodule
